// ===== hdl/hpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package hpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LNK_W    = IDX_W + 2;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_EXTRACT = 2'd1,
    FN_REMOVE  = 2'd2,
    FN_PEEK    = 2'd3
  } hpq_func_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2,
    STS_BADPOS = 2'd3
  } hpq_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } hpq_state_t;

  typedef struct packed {
    hpq_func_t               func;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } hpq_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    hpq_status_t             status;
    logic [CNT_W-1:0]        count;
  } hpq_res_t;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;
    logic [IDX_W-1:0]        raddr_a;
    logic [IDX_W-1:0]        raddr_b;
  } hpq_mem_t;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] dec;
    dec = idx - IDX_W'(1);
    return dec >> 1;
  endfunction

endpackage

// ===== hdl/hpq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module hpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/hpq_ctrl.sv =====
// Sequencer that walks the heap in memory for insert, extract, remove and peek.
module hpq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  hpq_pkg::hpq_req_t               req,
  output logic                            res_valid,
  input  logic                            res_ready,
  output hpq_pkg::hpq_res_t               res,
  output hpq_pkg::hpq_mem_t               mem,
  input  logic signed [hpq_pkg::VAL_W-1:0] rd_a,
  input  logic signed [hpq_pkg::VAL_W-1:0] rd_b
);

  import hpq_pkg::*;

  hpq_state_t              state_r, state_nxt;
  hpq_func_t               func_r, func_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  hpq_status_t             status_r, status_nxt;

  logic                    is_full;
  logic                    is_empty;
  logic                    is_badpos;
  logic [CNT_W-1:0]        last;
  logic                    at_last;
  logic                    go_up;
  logic [LNK_W-1:0]        left_w;
  logic [LNK_W-1:0]        right_w;
  logic [LNK_W-1:0]        count_w;
  logic                    no_child;
  logic                    pick_right;
  logic signed [VAL_W-1:0] pick_val;
  logic [IDX_W-1:0]        pick_idx;
  logic                    child_wins;
  logic                    parent_loses;

  assign is_full      = (32'(count_r) >= CAPACITY);
  assign is_empty     = (count_r == '0);
  assign is_badpos    = (32'(req.position) >= 32'(count_r));
  assign last         = count_r - CNT_W'(1);
  assign at_last      = (32'(idx_r) >= 32'(last));
  assign go_up        = (idx_r != '0) && (rd_b > rd_a);
  assign left_w       = (LNK_W'(idx_r) << 1) | LNK_W'(1);
  assign right_w      = left_w + LNK_W'(1);
  assign count_w      = LNK_W'(count_r);
  assign no_child     = (left_w >= count_w);
  assign pick_right   = (right_w < count_w) && (rd_b > rd_a);
  assign pick_val     = pick_right ? rd_b : rd_a;
  assign pick_idx     = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
  assign child_wins   = (pick_val > cur_r);
  assign parent_loses = (cur_r > rd_a);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.func == FN_INSERT) begin
            state_nxt = is_full ? ST_FIN : ST_UP_RD;
          end else if (is_empty) begin
            state_nxt = ST_FIN;
          end else if (req.func == FN_REMOVE && is_badpos) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (func_r == FN_PEEK || at_last) begin
          state_nxt = ST_FIN;
        end else if (go_up) begin
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        state_nxt = (idx_r == '0) ? ST_FIN : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_nxt = parent_loses ? ST_UP_RD : ST_FIN;
      end
      ST_DN_RD: begin
        state_nxt = no_child ? ST_FIN : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_nxt = child_wins ? ST_DN_RD : ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    func_nxt    = func_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    count_nxt   = count_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    mem.we      = 1'b0;
    mem.waddr   = idx_r;
    mem.wdata   = cur_r;
    mem.raddr_a = '0;
    mem.raddr_b = last[IDX_W-1:0];
    req_ready   = (state_r == ST_IDLE);
    res_valid   = (state_r == ST_FIN);
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          func_nxt   = req.func;
          val_nxt    = '0;
          status_nxt = STS_OK;
          idx_nxt    = '0;
          if (req.func == FN_INSERT) begin
            if (is_full) begin
              status_nxt = STS_FULL;
            end else begin
              idx_nxt   = count_r[IDX_W-1:0];
              cur_nxt   = req.value;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (is_empty) begin
            status_nxt = STS_EMPTY;
            val_nxt    = '1;
          end else if (req.func == FN_REMOVE) begin
            if (is_badpos) begin
              status_nxt = STS_BADPOS;
            end else begin
              idx_nxt     = IDX_W'(req.position);
              mem.raddr_a = parent_of(IDX_W'(req.position));
            end
          end
        end
      end
      ST_LOAD: begin
        if (func_r == FN_PEEK || func_r == FN_EXTRACT) begin
          val_nxt = rd_a;
        end
        if (func_r != FN_PEEK) begin
          count_nxt = last;
          cur_nxt   = rd_b;
        end
      end
      ST_UP_RD: begin
        if (idx_r == '0) begin
          mem.we = 1'b1;
        end else begin
          mem.raddr_a = parent_of(idx_r);
        end
      end
      ST_UP_CMP: begin
        mem.we = 1'b1;
        if (parent_loses) begin
          mem.wdata = rd_a;
          idx_nxt   = parent_of(idx_r);
        end
      end
      ST_DN_RD: begin
        if (no_child) begin
          mem.we = 1'b1;
        end else begin
          mem.raddr_a = left_w[IDX_W-1:0];
          mem.raddr_b = right_w[IDX_W-1:0];
        end
      end
      ST_DN_CMP: begin
        mem.we = 1'b1;
        if (child_wins) begin
          mem.wdata = pick_val;
          idx_nxt   = pick_idx;
        end
      end
      default: begin
      end
    endcase
    res.value  = val_r;
    res.status = status_r;
    res.count  = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== hdl/max_heap_priority_queue_unit.sv =====
// Rejected and empty requests go straight to the result state; peek returns the root.
// Insert sifts up one level per read-compare-write pass over the heap RAM; extract sifts
// the refilled root down, and remove sifts the refilled hole up or down, the same way.
// One request in flight; a new one is taken once the result is handed to the
// output register. Reset clears the entry count; RAM contents are not cleared.
module max_heap_priority_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[37:32], zero[39:38]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // result_value[31:0], status[33:32], count[40:34], zero
);

  import hpq_pkg::*;

  localparam int OUT_W = VAL_W + STAT_W + CNT_W;

  hpq_req_t                req;
  hpq_res_t                res;
  hpq_mem_t                mem;
  logic                    res_valid;
  logic                    res_ready;
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  assign req.func     = hpq_func_t'(in_tuser);
  assign req.value    = in_tdata[VAL_W-1:0];
  assign req.position = in_tdata[VAL_W +: POS_W];

  hpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  hpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (mem.wdata),
    .raddr_a (mem.raddr_a),
    .raddr_b (mem.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res.count, res.status, res.value};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(48 - OUT_W)'(0), out_data_r};

endmodule

// ===== hdl/hpq_chk.sv =====
// Port-level checker for the max-heap priority queue, bound to the top level.
module hpq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  import hpq_pkg::*;

  logic [VAL_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;
  logic [CNT_W-1:0]  res_count;

  assign res_value  = out_tdata[VAL_W-1:0];
  assign res_status = out_tdata[VAL_W +: STAT_W];
  assign res_count  = out_tdata[VAL_W + STAT_W +: CNT_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(res_count) <= CAPACITY)
    else $error("count above capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status == STS_EMPTY |-> res_count == '0 && res_value == '1)
    else $error("empty status with wrong value or count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status == STS_FULL |-> 32'(res_count) == CAPACITY && res_value == '0)
    else $error("full status with wrong value or count");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item right after reset");

endmodule

bind max_heap_priority_queue_unit hpq_chk u_hpq_chk (.*);

// ===== sim/max_heap_priority_queue_unit_tb.sv =====
// Self-checking testbench for the max-heap priority queue unit: directed table plus random traffic.
module max_heap_priority_queue_unit_tb;
  import hpq_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DIR_ROWS    = 26;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    hpq_status_t             status;
    logic [CNT_W-1:0]        count;
  } heap_result_t;

  typedef struct {
    hpq_func_t               func;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    bit                      typed;
    logic signed [VAL_W-1:0] exp_value;
    hpq_status_t             exp_status;
    logic [CNT_W-1:0]        exp_count;
  } heap_row_t;

  typedef enum int {GEN_FILL, GEN_MIX, GEN_DRAIN} gen_mode_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // value[31:0], position[37:32], zero[39:38]
  logic [1:0]  in_tuser   = '0;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // result_value[31:0], status[33:32], count[40:34], zero

  logic signed [VAL_W-1:0] shadow_heap [CAPACITY];
  int unsigned             shadow_count;
  heap_result_t            pending_results [$];

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  int fail_count    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int n_insert = 0, n_extract = 0, n_remove = 0, n_peek = 0;
  int n_full = 0, n_empty = 0, n_badpos = 0, peak_count = 0;

  heap_row_t dir_rows [DIR_ROWS] = '{
    '{FN_PEEK,    32'sd0,           6'd0,  1'b1, -32'sd1,         STS_EMPTY,  7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b1, -32'sd1,         STS_EMPTY,  7'd0},
    '{FN_REMOVE,  32'sd0,           6'd0,  1'b1, -32'sd1,         STS_EMPTY,  7'd0},
    '{FN_INSERT,  32'sh7fffffff,    6'd63, 1'b1, 32'sd0,          STS_OK,     7'd1},
    '{FN_INSERT,  32'sh80000000,    6'd0,  1'b1, 32'sd0,          STS_OK,     7'd2},
    '{FN_PEEK,    -32'sd1,          6'd63, 1'b1, 32'sh7fffffff,   STS_OK,     7'd2},
    '{FN_REMOVE,  32'sd0,           6'd63, 1'b1, 32'sd0,          STS_BADPOS, 7'd2},
    '{FN_REMOVE,  32'sd0,           6'd2,  1'b1, 32'sd0,          STS_BADPOS, 7'd2},
    '{FN_INSERT,  32'sd5,           6'd63, 1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  32'sd5,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  32'sd5,           6'd21, 1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  -32'sd1,          6'd42, 1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  32'sd100,         6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_REMOVE,  32'sd0,           6'd1,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_REMOVE,  32'sh7fffffff,    6'd6,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_REMOVE,  32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_PEEK,    32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_INSERT,  32'sh7fffffff,    6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b0, 32'sd0,          STS_OK,     7'd0},
    '{FN_EXTRACT, 32'sd0,           6'd0,  1'b1, -32'sd1,         STS_EMPTY,  7'd0}
  };

  max_heap_priority_queue_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void swap_shadow(int unsigned a, int unsigned b);
    logic signed [VAL_W-1:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void sift_up(int unsigned i);
    int unsigned up;
    while (i > 0 && i < shadow_count) begin
      up = (i - 1) / 2;
      if (!(shadow_heap[i] > shadow_heap[up])) break;
      swap_shadow(i, up);
      i = up;
    end
  endfunction

  function automatic void sink_entry(int unsigned i);
    int unsigned left;
    int unsigned pick;
    while (i < shadow_count) begin
      left = 2 * i + 1;
      if (left >= shadow_count) break;
      pick = left;
      if (left + 1 < shadow_count && shadow_heap[left + 1] > shadow_heap[left]) pick = left + 1;
      if (!(shadow_heap[pick] > shadow_heap[i])) break;
      swap_shadow(pick, i);
      i = pick;
    end
  endfunction

  function automatic void fill_hole(int unsigned pos);
    int unsigned last;
    last = shadow_count - 1;
    shadow_heap[pos] = shadow_heap[last];
    shadow_count = last;
    if (pos >= shadow_count) return;
    if (pos > 0 && shadow_heap[pos] > shadow_heap[(pos - 1) / 2]) sift_up(pos);
    else sink_entry(pos);
  endfunction

  function automatic heap_result_t heap_predict(hpq_func_t func, logic signed [VAL_W-1:0] value,
                                                logic [POS_W-1:0] pos);
    heap_result_t r;
    r.value  = '0;
    r.status = STS_OK;
    case (func)
      FN_INSERT: begin
        n_insert++;
        if (shadow_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          shadow_heap[shadow_count] = value;
          shadow_count++;
          sift_up(shadow_count - 1);
        end
      end
      default: begin
        if (func == FN_EXTRACT) n_extract++;
        else if (func == FN_REMOVE) n_remove++;
        else n_peek++;
        if (shadow_count == 0) begin
          r.status = STS_EMPTY;
          r.value  = -1;
        end else if (func == FN_EXTRACT) begin
          r.value = shadow_heap[0];
          fill_hole(0);
        end else if (func == FN_REMOVE) begin
          if (pos >= shadow_count) r.status = STS_BADPOS;
          else fill_hole(pos);
        end else begin
          r.value = shadow_heap[0];
        end
      end
    endcase
    case (r.status)
      STS_FULL:   n_full++;
      STS_EMPTY:  n_empty++;
      STS_BADPOS: n_badpos++;
      default:    ;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r <= 3) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
    return $urandom;
  endfunction

  function automatic void gen_item(input gen_mode_t mode, output hpq_func_t func,
                                   output logic signed [VAL_W-1:0] value,
                                   output logic [POS_W-1:0] pos);
    int r;
    int p_ins, p_ext, p_rmv, p_any;
    bit exact;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_FILL:  begin p_ins = 90; p_ext = 94; p_rmv = 97; p_any = 97; end
      GEN_DRAIN: begin p_ins = 8;  p_ext = 50; p_rmv = 82; p_any = 92; end
      default:   begin p_ins = 40; p_ext = 60; p_rmv = 80; p_any = 90; end
    endcase
    value = pick_value();
    pos   = POS_W'($urandom_range(0, 63));
    exact = 1'b0;
    if (r < p_ins) func = FN_INSERT;
    else if (r < p_ext) func = FN_EXTRACT;
    else if (r < p_rmv) begin func = FN_REMOVE; exact = 1'b1; end
    else if (r < p_any) func = FN_REMOVE;
    else func = FN_PEEK;
    if (exact && shadow_count > 0) pos = POS_W'($urandom_range(0, shadow_count - 1));
  endfunction

  task automatic offer_item(input hpq_func_t func, input logic signed [VAL_W-1:0] value,
                            input logic [POS_W-1:0] pos, output heap_result_t predicted);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, pos, value};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    predicted = heap_predict(func, value, pos);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_result(input logic [47:0] data);
    heap_result_t            want;
    logic signed [VAL_W-1:0] got_value;
    logic [STAT_W-1:0]       got_status;
    logic [CNT_W-1:0]        got_count;
    got_value  = data[31:0];
    got_status = data[33:32];
    got_count  = data[40:34];
    if (pending_results.size() == 0) begin
      $error("unexpected result item: tdata %h", data);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      checked_count++;
      if (got_value !== want.value) begin
        $error("result_value: expected %0d, actual %0d", want.value, got_value);
        fail_count++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_status);
        fail_count++;
      end
      if (got_count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got_count);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("max_heap_priority_queue_unit: mismatch");
    $finish;
  end

  initial begin
    heap_result_t            predicted;
    heap_result_t            typed_exp;
    hpq_func_t               func;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    gen_mode_t               mode;
    int                      seg_len;

    shadow_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].func, dir_rows[i].value, dir_rows[i].position, predicted);
      if (dir_rows[i].typed) begin
        typed_exp.value  = dir_rows[i].exp_value;
        typed_exp.status = dir_rows[i].exp_status;
        typed_exp.count  = dir_rows[i].exp_count;
        pending_results.push_back(typed_exp);
      end else begin
        pending_results.push_back(predicted);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
        default: begin snd_idle_pct = 10; rcv_stall_pct = 10; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0:       begin mode = GEN_FILL;  seg_len = 90; end
          2:       begin mode = GEN_DRAIN; seg_len = 80; end
          default: begin mode = GEN_MIX;   seg_len = 60; end
        endcase
        // starve the output so the block backs up onto its input
        if (seg == 1 && (ph == 0 || ph == 2)) hold_req = 1'b1;
        for (int k = 0; k < seg_len; k++) begin
          gen_item(mode, func, value, pos);
          offer_item(func, value, pos, predicted);
          pending_results.push_back(predicted);
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d insert, %0d extract, %0d remove, %0d peek",
             sent_count, checked_count, n_insert, n_extract, n_remove, n_peek);
    $display("%0d full rejects, %0d on empty heap, %0d bad position; heap peaked at %0d entries",
             n_full, n_empty, n_badpos, peak_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("max_heap_priority_queue_unit: match");
    end else begin
      $display("max_heap_priority_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hpq_pkg.sv
hdl/hpq_ram.sv
hdl/hpq_ctrl.sv
hdl/max_heap_priority_queue_unit.sv
hdl/hpq_chk.sv
sim/max_heap_priority_queue_unit_tb.sv
